// ----- rtl/core/mp2d_pkg.sv -----
// Package for the 2-D max pooling core.
// Holds register indexes, field widths, reset values, the controller state type
// and the command and status structs shared by the controller and the datapath.
package mp2d_pkg;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 11;
    localparam int POOL_FIELD_W = 3;
    localparam int DIM_FIELD_W  = 9;
    localparam int CHAN_FIELD_W = 11;
    localparam int CHAN_W       = 10;
    localparam int MAX_CHANNELS = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_POOL_SIZE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_STEP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

    localparam logic [POOL_FIELD_W-1:0] RESET_POOL_SIZE     = 3'd2;
    localparam logic [POOL_FIELD_W-1:0] RESET_STRIDE_STEP   = 3'd2;
    localparam logic [DIM_FIELD_W-1:0]  RESET_IMAGE_HEIGHT  = 9'd28;
    localparam logic [DIM_FIELD_W-1:0]  RESET_IMAGE_WIDTH   = 9'd28;
    localparam logic [CHAN_FIELD_W-1:0] RESET_CHANNEL_COUNT = 11'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic push;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic row_emit;
        logic rd_last;
        logic col_emit;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/core/mp2d_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mp2d_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mp2d_ctrl.sv -----
// Sequencing state machine for the max pooling core.
// Depends on mp2d_pkg for the state type and the command and status structs.
module mp2d_ctrl import mp2d_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.row_emit) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.push = 1'b1;
                n_state    = i_status.col_emit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/mp2d_datapath.sv -----
// Datapath of the max pooling core: configuration, position counters, line store,
// column maximum, window maximum and output register.
// Depends on mp2d_pkg and mp2d_ram.
module mp2d_datapath import mp2d_pkg::*; #(
    parameter int MAX_POOL    = 4,
    parameter int MAX_WIDTH   = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_pooled_value,
    output logic                          o_last_of_volume
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SLOT_W    = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int CM_DEPTH  = (MAX_POOL > 1) ? MAX_POOL - 1 : 1;
    localparam int RAM_DEPTH = MAX_POOL * (2 ** COL_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    function automatic logic [SLOT_W-1:0] clamp_pool(input logic [POOL_FIELD_W-1:0] v);
        if (v == '0) begin
            clamp_pool = '0;
        end else if (int'(v) > MAX_POOL) begin
            clamp_pool = SLOT_W'(MAX_POOL - 1);
        end else begin
            clamp_pool = SLOT_W'(v - 1'b1);
        end
    endfunction

    function automatic logic [COL_W-1:0] clamp_dim(input logic [DIM_FIELD_W-1:0] v);
        if (v == '0) begin
            clamp_dim = '0;
        end else if (int'(v) > MAX_WIDTH) begin
            clamp_dim = COL_W'(MAX_WIDTH - 1);
        end else begin
            clamp_dim = COL_W'(v - 1'b1);
        end
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_FIELD_W-1:0] v);
        if (v == '0) begin
            clamp_chan = '0;
        end else if (int'(v) > MAX_CHANNELS) begin
            clamp_chan = CHAN_W'(MAX_CHANNELS - 1);
        end else begin
            clamp_chan = CHAN_W'(v - 1'b1);
        end
    endfunction

    // configuration, kept as clamped value minus one
    logic [SLOT_W-1:0] r_pm1, n_pm1;
    logic [SLOT_W-1:0] r_sm1, n_sm1;
    logic [COL_W-1:0]  r_hm1, n_hm1;
    logic [COL_W-1:0]  r_wm1, n_wm1;
    logic [CHAN_W-1:0] r_cm1, n_cm1;

    // stream position
    logic [COL_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CHAN_W-1:0] r_chan, n_chan;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_row_wait, n_row_wait;
    logic [SLOT_W-1:0] r_col_wait, n_col_wait;

    // item context
    logic [COL_W-1:0]              r_cur_col;
    logic                          r_col_emit;
    logic                          r_last;
    logic [SLOT_W-1:0]             r_rd_idx;
    logic                          r_rd_vld;
    logic signed [SAMPLE_BITS-1:0] r_acc;
    logic signed [SAMPLE_BITS-1:0] r_colmax [CM_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_win;
    logic                          r_win_last;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_last;

    logic                          w_cfg_hit;
    logic                          w_last_now;
    logic [COL_W:0]                w_row_reach;
    logic [COL_W:0]                w_col_reach;
    logic [SLOT_W+COL_W-1:0]       w_waddr;
    logic [SLOT_W+COL_W-1:0]       w_raddr;
    logic [SAMPLE_BITS-1:0]        w_rdata_raw;
    logic signed [SAMPLE_BITS-1:0] w_rdata;
    logic signed [SAMPLE_BITS-1:0] w_acc_next;
    logic signed [SAMPLE_BITS-1:0] w_win;

    always_comb begin
        n_pm1     = r_pm1;
        n_sm1     = r_sm1;
        n_hm1     = r_hm1;
        n_wm1     = r_wm1;
        n_cm1     = r_cm1;
        w_cfg_hit = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POOL_SIZE: begin
                    n_pm1     = clamp_pool(i_cfg_data[POOL_FIELD_W-1:0]);
                    w_cfg_hit = 1'b1;
                end
                REG_STRIDE_STEP: begin
                    n_sm1     = clamp_pool(i_cfg_data[POOL_FIELD_W-1:0]);
                    w_cfg_hit = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    n_hm1     = clamp_dim(i_cfg_data[DIM_FIELD_W-1:0]);
                    w_cfg_hit = 1'b1;
                end
                REG_IMAGE_WIDTH: begin
                    n_wm1     = clamp_dim(i_cfg_data[DIM_FIELD_W-1:0]);
                    w_cfg_hit = 1'b1;
                end
                REG_CHANNEL_COUNT: begin
                    n_cm1     = clamp_chan(i_cfg_data[CHAN_FIELD_W-1:0]);
                    w_cfg_hit = 1'b1;
                end
                default: begin
                    w_cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_chan     = r_chan;
        n_slot     = r_slot;
        n_row_wait = r_row_wait;
        n_col_wait = r_col_wait;
        if (w_cfg_hit) begin
            n_row      = '0;
            n_col      = '0;
            n_chan     = '0;
            n_slot     = '0;
            n_row_wait = n_pm1;
            n_col_wait = n_pm1;
        end else if (i_cmd.accept) begin
            if (r_col == r_wm1) begin
                n_col      = '0;
                n_col_wait = r_pm1;
                if (r_row == r_hm1) begin
                    n_row      = '0;
                    n_slot     = '0;
                    n_row_wait = r_pm1;
                    n_chan     = (r_chan == r_cm1) ? '0 : r_chan + 1'b1;
                end else begin
                    n_row      = r_row + 1'b1;
                    n_slot     = (r_slot == r_pm1) ? '0 : r_slot + 1'b1;
                    n_row_wait = (r_row_wait == '0) ? r_sm1 : r_row_wait - 1'b1;
                end
            end else begin
                n_col      = r_col + 1'b1;
                n_col_wait = (r_col_wait == '0) ? r_sm1 : r_col_wait - 1'b1;
            end
        end
    end

    // no later window origin fits below or to the right
    assign w_row_reach = (COL_W+1)'(r_row) + (COL_W+1)'(r_sm1);
    assign w_col_reach = (COL_W+1)'(r_col) + (COL_W+1)'(r_sm1);
    assign w_last_now  = (r_chan == r_cm1) && (w_row_reach >= (COL_W+1)'(r_hm1))
                         && (w_col_reach >= (COL_W+1)'(r_wm1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm1      <= clamp_pool(RESET_POOL_SIZE);
            r_sm1      <= clamp_pool(RESET_STRIDE_STEP);
            r_hm1      <= clamp_dim(RESET_IMAGE_HEIGHT);
            r_wm1      <= clamp_dim(RESET_IMAGE_WIDTH);
            r_cm1      <= clamp_chan(RESET_CHANNEL_COUNT);
            r_row      <= '0;
            r_col      <= '0;
            r_chan     <= '0;
            r_slot     <= '0;
            r_row_wait <= clamp_pool(RESET_POOL_SIZE);
            r_col_wait <= clamp_pool(RESET_POOL_SIZE);
            r_rd_vld   <= 1'b0;
        end else begin
            r_pm1      <= n_pm1;
            r_sm1      <= n_sm1;
            r_hm1      <= n_hm1;
            r_wm1      <= n_wm1;
            r_cm1      <= n_cm1;
            r_row      <= n_row;
            r_col      <= n_col;
            r_chan     <= n_chan;
            r_slot     <= n_slot;
            r_row_wait <= n_row_wait;
            r_col_wait <= n_col_wait;
            r_rd_vld   <= i_cmd.rd_issue;
        end
    end

    // line store, one row slot per window row
    assign w_waddr = {r_slot, r_col};
    assign w_raddr = {r_rd_idx, r_cur_col};

    mp2d_ram #(
        .DATA_W (SAMPLE_BITS),
        .DEPTH  (RAM_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (RAM_AW'(w_waddr)),
        .i_wdata (i_sample),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (RAM_AW'(w_raddr)),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata    = w_rdata_raw;
    assign w_acc_next = (r_rd_vld && (w_rdata > r_acc)) ? w_rdata : r_acc;

    always_comb begin
        w_win = w_acc_next;
        for (int k = 0; k < CM_DEPTH; k++) begin
            if ((SLOT_W'(k) < r_pm1) && (r_colmax[k] > w_win)) begin
                w_win = r_colmax[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_col  <= r_col;
            r_col_emit <= (r_col_wait == '0);
            r_last     <= w_last_now;
            r_rd_idx   <= '0;
            r_acc      <= i_sample;
        end else begin
            if (i_cmd.rd_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_rd_vld) begin
                r_acc <= w_acc_next;
            end
        end
        if (i_cmd.push) begin
            r_colmax[0] <= w_acc_next;
            for (int k = 1; k < CM_DEPTH; k++) begin
                r_colmax[k] <= r_colmax[k-1];
            end
            r_win      <= w_win;
            r_win_last <= r_last;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_win;
            r_out_last  <= r_win_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.row_emit = (r_row_wait == '0);
    assign o_status.rd_last  = (r_rd_idx == r_pm1);
    assign o_status.col_emit = r_col_emit;
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid          = r_out_valid;
    assign o_pooled_value   = r_out_value;
    assign o_last_of_volume = r_out_last;

endmodule

// ----- rtl/core/max_pool_2d_core.sv -----
// Streaming 2-D max pooling core, top level.
// Samples enter on i_valid/o_stall, channel by channel in raster order. Results
// leave on o_valid/i_stall: one window maximum per completed pool_size square
// whose origin sits on the stride grid; o_last_of_volume marks the final one.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is high
// (0 pool_size, 1 stride_step, 2 image_height, 3 image_width, 4 channel_count),
// only while the core is idle. A write to one of these registers restarts the volume
// at row 0, column 0. Timing: a sample on a row that closes no window leaves the
// core idle, ready for the next sample. A sample on a row that closes windows stalls
// the input for one line-store read per window row for its column, then the column
// maximum joins the last columns. A sample that closes a window then loads the output
// register in ST_EMIT, after the reads and the column push in ST_DRAIN. The output
// register lets the next sample enter while a result waits; a result still held adds
// a stall only when the next result is ready to load.
// Reset (synchronous, i_rst_n low) restores the default registers and positions;
// line store contents are not cleared.
// Depends on mp2d_pkg, mp2d_ctrl, mp2d_datapath and mp2d_ram.
module max_pool_2d_core import mp2d_pkg::*; #(
    parameter int MAX_POOL    = 4,
    parameter int MAX_WIDTH   = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_pooled_value,
    output logic                          o_last_of_volume
);

    t_cmd    w_cmd;
    t_status w_status;

    mp2d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mp2d_datapath #(
        .MAX_POOL    (MAX_POOL),
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_sample),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_pooled_value   (o_pooled_value),
        .o_last_of_volume (o_last_of_volume)
    );

endmodule

// ----- tb/max_pool_2d_core_test.sv -----
// Self-checking testbench for max_pool_2d_core: streams feature volumes under
// changing register settings and checks every window maximum against a local model.
// Depends on mp2d_pkg and the max_pool_2d_core RTL.
module max_pool_2d_core_test import mp2d_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POOL       = 4;
    localparam int MAX_WIDTH      = 256;
    localparam int SAMPLE_W       = 16;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 200;
    localparam int CLOSING_ITEMS  = 100;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } t_window_max;

    typedef logic [CFG_DATA_W-1:0] t_reg_set [5];

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       sample_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       result_stall = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_pooled_value;
    logic                       o_last_of_volume;

    // window model state
    logic signed [SAMPLE_W-1:0] kept_rows [MAX_POOL][MAX_WIDTH];
    logic [POOL_FIELD_W-1:0]    cfg_pool;
    logic [POOL_FIELD_W-1:0]    cfg_stride;
    logic [DIM_FIELD_W-1:0]     cfg_height;
    logic [DIM_FIELD_W-1:0]     cfg_width;
    logic [CHAN_FIELD_W-1:0]    cfg_chans;
    int                         row_pos;
    int                         col_pos;
    int                         chan_pos;

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    t_window_max                pending_maxima [$];
    t_window_max                want;

    int mismatches     = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int no_idling      = 0;
    int holds_asked    = 0;
    int holds_served   = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;
    int random_items   = 0;

    max_pool_2d_core #(
        .MAX_POOL    (MAX_POOL),
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_valid          (sample_valid),
        .o_stall          (o_stall),
        .i_sample         (sample_in),
        .o_valid          (o_valid),
        .i_stall          (result_stall),
        .o_pooled_value   (o_pooled_value),
        .o_last_of_volume (o_last_of_volume)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp_to(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [CFG_INDEX_W-1:0] reg_at(input int k);
        case (k)
            0: return REG_POOL_SIZE;
            1: return REG_STRIDE_STEP;
            2: return REG_IMAGE_HEIGHT;
            3: return REG_IMAGE_WIDTH;
            default: return REG_CHANNEL_COUNT;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3: return SAMPLE_W'($signed($urandom_range(7)) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 5;
            2: return 25;
            default: return 50;
        endcase
    endfunction

    task automatic clear_window_model();
        cfg_pool   = RESET_POOL_SIZE;
        cfg_stride = RESET_STRIDE_STEP;
        cfg_height = RESET_IMAGE_HEIGHT;
        cfg_width  = RESET_IMAGE_WIDTH;
        cfg_chans  = RESET_CHANNEL_COUNT;
        row_pos    = 0;
        col_pos    = 0;
        chan_pos   = 0;
        pending_maxima.delete();
    endtask

    task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_POOL_SIZE:     cfg_pool   = data[POOL_FIELD_W-1:0];
            REG_STRIDE_STEP:   cfg_stride = data[POOL_FIELD_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_height = data[DIM_FIELD_W-1:0];
            REG_IMAGE_WIDTH:   cfg_width  = data[DIM_FIELD_W-1:0];
            REG_CHANNEL_COUNT: cfg_chans  = data[CHAN_FIELD_W-1:0];
            default: return;
        endcase
        row_pos  = 0;
        col_pos  = 0;
        chan_pos = 0;
    endtask

    // store the sample; if it closes a window on the stride grid, queue its max
    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] smp);
        int p, s, h, w, c, r, col, slot, k, top, left;
        t_window_max res;
        p   = clamp_to(cfg_pool, 1, MAX_POOL);
        s   = clamp_to(cfg_stride, 1, MAX_POOL);
        h   = clamp_to(cfg_height, 1, MAX_WIDTH);
        w   = clamp_to(cfg_width, 1, MAX_WIDTH);
        c   = clamp_to(cfg_chans, 1, MAX_CHANNELS);
        r   = row_pos;
        col = col_pos;
        if (r >= h) r = h - 1;
        if (col >= w) col = w - 1;
        kept_rows[r % p][col] = smp;
        if (r + 1 >= p && col + 1 >= p && (r + 1 - p) % s == 0 && (col + 1 - p) % s == 0) begin
            res.value = kept_rows[0][col + 1 - p];
            for (slot = 0; slot < p; slot++) begin
                for (k = col + 1 - p; k <= col; k++) begin
                    if (kept_rows[slot][k] > res.value) res.value = kept_rows[slot][k];
                end
            end
            top  = ((h - p) / s) * s;
            left = ((w - p) / s) * s;
            res.last = (chan_pos + 1 >= c && r + 1 - p == top && col + 1 - p == left);
            pending_maxima.push_back(res);
        end
        col++;
        if (col >= w) begin
            col = 0;
            r++;
            if (r >= h) begin
                r = 0;
                chan_pos++;
                if (chan_pos >= c) chan_pos = 0;
            end
        end
        row_pos = r;
        col_pos = col;
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            sample_valid <= 1'b0;
            gap_left     <= 0;
        end else if (!sample_valid || !o_stall) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                sample_valid <= 1'b0;
            end else if (pending_samples.size() != 0 && no_idling == 0 &&
                         $urandom_range(99) < send_gap_pct) begin
                gap_left     <= $urandom_range(16);
                sample_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                sample_valid <= 1'b1;
                sample_in    <= pending_samples.pop_front();
            end else begin
                sample_valid <= 1'b0;
            end
        end
    end

    // result side stall
    always @(posedge clk) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            stall_left   <= LONG_HOLD - 1;
            result_stall <= 1'b1;
        end else if (no_idling == 0 && $urandom_range(99) < recv_stall_pct) begin
            stall_left   <= $urandom_range(16);
            result_stall <= 1'b1;
        end else begin
            result_stall <= 1'b0;
        end
    end

    // monitor: check results, track register writes, predict accepted items
    always @(posedge clk) begin
        if (!rst_n) begin
            clear_window_model();
        end else begin
            if (o_valid && !result_stall) begin
                if (pending_maxima.size() == 0) begin
                    $error("unexpected result: pooled_value %0d last_of_volume %0b",
                           o_pooled_value, o_last_of_volume);
                    mismatches++;
                end else begin
                    want = pending_maxima.pop_front();
                    if (o_pooled_value !== want.value) begin
                        $error("pooled_value: expected %0d, got %0d",
                               want.value, o_pooled_value);
                        mismatches++;
                    end
                    if (o_last_of_volume !== want.last) begin
                        $error("last_of_volume: expected %0b, got %0b",
                               want.last, o_last_of_volume);
                        mismatches++;
                    end
                end
            end
            if (cfg_we) apply_register(cfg_index, cfg_data);
            if (sample_valid && !o_stall) absorb_sample(sample_in);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (sample_valid && !o_stall) || (o_valid && !result_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("max_pool_2d_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || pending_maxima.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic offer_samples(input int n);
        int k;
        for (k = 0; k < n; k++) pending_samples.push_back(pick_sample());
    endtask

    task automatic run_phase(input t_reg_set setting, input int items,
                             input bit split, input bit long_hold);
        int order [5];
        int j, t, tmp;
        wait_drained();
        for (j = 0; j < 5; j++) order[j] = j;
        for (j = 4; j > 0; j--) begin
            t        = $urandom_range(j);
            tmp      = order[j];
            order[j] = order[t];
            order[t] = tmp;
        end
        for (j = 0; j < 5; j++) reg_write(reg_at(order[j]), setting[order[j]]);
        @(negedge clk);
        send_gap_pct   = long_hold ? 0 : pick_pct();
        recv_stall_pct = pick_pct();
        if (long_hold) holds_asked++;
        if (split) begin
            offer_samples(items / 2);
            wait_drained();
            offer_samples(items - items / 2);
        end else begin
            offer_samples(items);
        end
    endtask

    task automatic run_random_phase(input bit split, input int cap);
        t_reg_set setting;
        int vol, items;
        setting[0] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                              : CFG_DATA_W'($urandom_range(1, MAX_POOL));
        setting[1] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                              : CFG_DATA_W'($urandom_range(1, MAX_POOL));
        setting[2] = CFG_DATA_W'($urandom_range(10));
        setting[3] = CFG_DATA_W'($urandom_range(10));
        if ($urandom_range(3) == 0) setting[2][10:9] = 2'($urandom);
        if ($urandom_range(3) == 0) setting[3][10:9] = 2'($urandom);
        setting[4] = CFG_DATA_W'($urandom_range(3));
        vol = clamp_to(setting[2][DIM_FIELD_W-1:0], 1, MAX_WIDTH) *
              clamp_to(setting[3][DIM_FIELD_W-1:0], 1, MAX_WIDTH) *
              clamp_to(setting[4], 1, MAX_CHANNELS);
        case ($urandom_range(2))
            0: items = vol;
            1: items = 2 * vol;
            default: items = $urandom_range(1, vol);
        endcase
        if (items > cap) items = cap;
        run_phase(setting, items, split, 1'b0);
        random_items += items;
    endtask

    initial begin
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // overlapping 2x2 windows, signed extremes
        run_phase('{2, 1, 2, 4, 1}, 0, 1'b0, 1'b0);
        pending_samples = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd0,
                            16'sd1, 16'sh8000, 16'sh8000, -16'sd2};
        // pool larger than image: no results
        run_phase('{3, 2, 2, 2, 1}, 4, 1'b0, 1'b0);
        // zero registers saturate up to 1: every item is a window
        run_phase('{0, 7, 0, 0, 0}, 0, 1'b0, 1'b0);
        pending_samples = '{16'sh8000, 16'sh7fff, 16'sd0};

        // dimension and channel extremes, masked and saturated
        run_phase('{1, 2, 2047, 1, 1}, 256, 1'b0, 1'b0);
        run_phase('{1, 3, 1, 2047, 1}, 256, 1'b0, 1'b0);
        run_phase('{1, 1, 1, 1, 2047}, 40, 1'b0, 1'b0);
        run_phase('{2047, 2047, 4, 8, 1}, 32, 1'b0, 1'b0);

        // long output hold while input keeps coming
        run_phase('{2, 1, 8, 8, 2}, 128, 1'b0, 1'b1);

        run_random_phase(1'b1, 200);
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(4) == 0) begin
                // unmapped index: volume position must carry on
                wait_drained();
                reg_write(CFG_INDEX_W'(int'(REG_CHANNEL_COUNT) + 1 + $urandom_range(2)),
                          CFG_DATA_W'($urandom));
                @(negedge clk);
                n = $urandom_range(1, 40);
                offer_samples(n);
                random_items += n;
            end else begin
                run_random_phase(1'b0, 200);
            end
        end

        wait_drained();
        no_idling = 1;
        run_random_phase(1'b0, CLOSING_ITEMS);
        wait_drained();

        if (mismatches == 0) begin
            $display("max_pool_2d_core verification clean");
        end else begin
            $display("max_pool_2d_core verification failed");
        end
        $finish;
    end

endmodule
